@@ rtl/mm4_pkg.sv @@
// Shared types and constants for the 4x4 fixed-point matrix multiplier.
package mm4_pkg;

	localparam int DIM = 4;
	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int PROD_W = 2 * DATA_W;
	// Four products of 64 bits need two guard bits.
	localparam int ACC_W = PROD_W + 2;

	localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
	localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
	localparam logic [1:0] OP_MULTIPLY   = 2'd2;

	typedef enum logic [1:0] {
		SEQ_IDLE,
		SEQ_FEED,
		SEQ_DRAIN
	} seq_state_t;

	// One left-matrix element travelling down the chain with its tags.
	typedef struct packed {
		logic              vld;
		logic              first;
		logic              last;
		logic [1:0]        k;
		logic [1:0]        row;
		logic [DATA_W-1:0] a;
	} lane_t;

	// Completion status of one cell.
	typedef struct packed {
		logic       done;
		logic [1:0] row;
	} cell_stat_t;

endpackage

@@ rtl/mm4_cell.sv @@
// One column cell: holds a right-matrix column, multiplies and accumulates a row.
module mm4_cell (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  mm4_pkg::lane_t         lane_i,
	output mm4_pkg::lane_t         lane_o,
	input  logic                   wr_en,
	input  logic [1:0]             wr_row,
	input  logic [31:0]            wr_data,
	output logic [31:0]            res,
	output mm4_pkg::cell_stat_t    stat
);
	import mm4_pkg::*;

	logic [DATA_W-1:0]        rcol_q [DIM];
	lane_t                    lane_s1;
	lane_t                    lane_s2;
	logic signed [PROD_W-1:0] prod_s2;
	cell_stat_t               stat_s3;
	cell_stat_t               stat_s4;
	logic signed [ACC_W-1:0]  acc_q;
	logic [DATA_W-1:0]        res_q;
	logic signed [ACC_W-FRAC_BITS-1:0] shifted;
	logic                     ovf;
	logic [DATA_W-1:0]        sat_val;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rcol_q[wr_row] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lane_s1 <= '0;
			lane_s2 <= '0;
			stat_s3 <= '0;
			stat_s4 <= '0;
		end else if (en) begin
			lane_s1 <= lane_i;
			lane_s2 <= lane_s1;
			stat_s3.done <= lane_s2.vld & lane_s2.last;
			stat_s3.row <= lane_s2.row;
			stat_s4 <= stat_s3;
		end
	end

	// Floor shift of the full-precision sum, then saturation to 32 bits.
	always_comb begin
		shifted = acc_q[ACC_W-1:FRAC_BITS];
		ovf = (shifted[ACC_W-FRAC_BITS-1:DATA_W-1] != '0) &&
			(shifted[ACC_W-FRAC_BITS-1:DATA_W-1] != '1);
		if (ovf) begin
			sat_val = shifted[ACC_W-FRAC_BITS-1] ? {1'b1, {(DATA_W-1){1'b0}}}
				: {1'b0, {(DATA_W-1){1'b1}}};
		end else begin
			sat_val = shifted[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s2 <= $signed(lane_s1.a) * $signed(rcol_q[lane_s1.k]);
			if (lane_s2.vld) begin
				acc_q <= (lane_s2.first ? ACC_W'(0) : acc_q) + ACC_W'(prod_s2);
			end
			if (stat_s3.done) begin
				res_q <= sat_val;
			end
		end
	end

	assign lane_o = lane_s1;
	assign res = res_q;
	assign stat = stat_s4;

endmodule

@@ rtl/matrix_multiply_4x4_unit.sv @@
// Top level of the 4x4 Q16.16 matrix multiplier built from a chain of column cells.
//
//  channel  handshake               payload
//  input    in_valid / in_ready     opcode, row_sel, in_c0..in_c3
//  output   out_valid / out_ready   out_row, prod_c0..prod_c3, last_row
//
// A multiply feeds 16 left elements down the chain, one per cycle while the output
// register is not stalled; each cell's single multiplier takes four of them for its
// entry of each product row. No new item is taken until the fourth row sits in the
// output register.
// A stalled output register freezes the whole chain; nothing is dropped.
// Reset clears control only; matrix contents are undefined until loaded.
module matrix_multiply_4x4_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  opcode,
	input  logic [1:0]  row_sel,
	input  logic [31:0] in_c0,
	input  logic [31:0] in_c1,
	input  logic [31:0] in_c2,
	input  logic [31:0] in_c3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  out_row,
	output logic [31:0] prod_c0,
	output logic [31:0] prod_c1,
	output logic [31:0] prod_c2,
	output logic [31:0] prod_c3,
	output logic        last_row
);
	import mm4_pkg::*;

	seq_state_t        state_q;
	seq_state_t        state_d;
	logic [3:0]        cnt_q;
	logic              en;
	logic              accept;
	logic              row_out;
	logic [DATA_W-1:0] left_q [DIM*DIM];
	logic [DATA_W-1:0] col_data [DIM];
	lane_t             feed_lane;
	lane_t             chain [DIM+1];
	logic [DATA_W-1:0] res [DIM];
	cell_stat_t        stat [DIM];
	logic              out_valid_q;
	logic [1:0]        out_row_q;
	logic [DATA_W-1:0] out_c_q [DIM];

	assign en = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;
	assign row_out = en && stat[DIM-1].done;

	assign col_data[0] = in_c0;
	assign col_data[1] = in_c1;
	assign col_data[2] = in_c2;
	assign col_data[3] = in_c3;

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_LOAD_LEFT) begin
			for (int c = 0; c < DIM; c++) begin
				left_q[{row_sel, 2'(c)}] <= col_data[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SEQ_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == SEQ_FEED && en) begin
				cnt_q <= cnt_q + 4'd1;
			end else if (state_q == SEQ_IDLE) begin
				cnt_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		feed_lane = '0;
		case (state_q)
			SEQ_IDLE: begin
				in_ready = 1'b1;
				if (accept && opcode == OP_MULTIPLY) begin
					state_d = SEQ_FEED;
				end
			end
			SEQ_FEED: begin
				feed_lane.vld = 1'b1;
				feed_lane.k = cnt_q[1:0];
				feed_lane.row = cnt_q[3:2];
				feed_lane.first = cnt_q[1:0] == 2'd0;
				feed_lane.last = cnt_q[1:0] == 2'd3;
				feed_lane.a = left_q[cnt_q];
				if (en && cnt_q == 4'd15) begin
					state_d = SEQ_DRAIN;
				end
			end
			SEQ_DRAIN: begin
				if (row_out && stat[DIM-1].row == 2'd3) begin
					state_d = SEQ_IDLE;
				end
			end
			default: begin
				state_d = SEQ_IDLE;
			end
		endcase
	end

	assign chain[0] = feed_lane;

	for (genvar j = 0; j < DIM; j++) begin : g_cell
		mm4_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.lane_i  (chain[j]),
			.lane_o  (chain[j+1]),
			.wr_en   (accept && opcode == OP_LOAD_RIGHT),
			.wr_row  (row_sel),
			.wr_data (col_data[j]),
			.res     (res[j]),
			.stat    (stat[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= stat[DIM-1].done;
		end
	end

	// Earlier cells still hold their result for this row when the last cell finishes.
	always_ff @(posedge clk) begin
		if (row_out) begin
			out_row_q <= stat[DIM-1].row;
			for (int c = 0; c < DIM; c++) begin
				out_c_q[c] <= res[c];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_row = out_row_q;
	assign prod_c0 = out_c_q[0];
	assign prod_c1 = out_c_q[1];
	assign prod_c2 = out_c_q[2];
	assign prod_c3 = out_c_q[3];
	assign last_row = out_row_q == 2'd3;

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the 4x4 Q16.16 matrix multiplier.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mm4_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int RANDOM_ITEMS = 350;
	localparam int TAIL_CYCLES = 40;
	localparam int PRINT_CAP = 100;

	typedef logic [DIM-1:0][DATA_W-1:0] row_vec_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] row;
		row_vec_t   col;
		logic [1:0] phase;
	} mm_cmd_t;

	typedef struct packed {
		logic [1:0] row;
		row_vec_t   val;
		logic       last;
	} prod_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  opcode = '0;
	logic [1:0]  row_sel = '0;
	logic [31:0] in_c0 = '0;
	logic [31:0] in_c1 = '0;
	logic [31:0] in_c2 = '0;
	logic [31:0] in_c3 = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  out_row;
	logic [31:0] prod_c0;
	logic [31:0] prod_c1;
	logic [31:0] prod_c2;
	logic [31:0] prod_c3;
	logic        last_row;

	mm_cmd_t   pending_cmds[$];
	prod_row_t expected_rows[$];
	mm_cmd_t   drv_cmd;
	logic [1:0] test_phase = '0;
	int        mismatch_count = 0;
	int        n_items = 0;

	logic [DATA_W-1:0] left_mat [DIM][DIM];
	logic [DATA_W-1:0] right_mat [DIM][DIM];

	matrix_multiply_4x4_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.row_sel   (row_sel),
		.in_c0     (in_c0),
		.in_c1     (in_c1),
		.in_c2     (in_c2),
		.in_c3     (in_c3),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_row   (out_row),
		.prod_c0   (prod_c0),
		.prod_c1   (prod_c1),
		.prod_c2   (prod_c2),
		.prod_c3   (prod_c3),
		.last_row  (last_row)
	);

	initial forever #10 clk = ~clk;

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= PRINT_CAP)
			$display("mismatch: %s", msg);
	endtask

	function automatic int sender_idle_pct(input logic [1:0] phase);
		case (phase)
			2'd0:    return 38;
			2'd1:    return 71;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct(input logic [1:0] phase);
		case (phase)
			2'd0:    return 71;
			2'd1:    return 38;
			default: return 0;
		endcase
	endfunction

	// Full-precision dot product, floor shift by the fraction width, then saturation.
	function automatic logic [DATA_W-1:0] dot_q16(input int r, input int c);
		logic signed [ACC_W-1:0] acc;
		logic signed [ACC_W-1:0] a;
		logic signed [ACC_W-1:0] b;
		logic signed [ACC_W-1:0] q_max;
		logic signed [ACC_W-1:0] q_min;
		acc = '0;
		q_max = $signed(32'h7FFF_FFFF);
		q_min = $signed(32'h8000_0000);
		for (int k = 0; k < DIM; k++) begin
			a = $signed(left_mat[r][k]);
			b = $signed(right_mat[k][c]);
			acc = acc + a * b;
		end
		acc = acc >>> FRAC_BITS;
		if (acc > q_max)
			acc = q_max;
		if (acc < q_min)
			acc = q_min;
		return acc[DATA_W-1:0];
	endfunction

	task automatic apply_cmd(input mm_cmd_t cmd);
		prod_row_t pr;
		case (cmd.op)
			OP_LOAD_LEFT: begin
				for (int j = 0; j < DIM; j++)
					left_mat[cmd.row][j] = cmd.col[j];
			end
			OP_LOAD_RIGHT: begin
				for (int j = 0; j < DIM; j++)
					right_mat[cmd.row][j] = cmd.col[j];
			end
			OP_MULTIPLY: begin
				for (int r = 0; r < DIM; r++) begin
					pr.row = 2'(r);
					for (int j = 0; j < DIM; j++)
						pr.val[j] = dot_q16(r, j);
					pr.last = (r == DIM - 1);
					expected_rows.push_back(pr);
				end
			end
			default: ;
		endcase
	endtask

	function automatic logic [DATA_W-1:0] rand_elem();
		case ($urandom_range(0, 4))
			0: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
			1: return 32'($urandom_range(0, 32'h0000_FFFF)) - 32'h0000_8000;
			2: begin
				case ($urandom_range(0, 3))
					0:       return 32'h8000_0000;
					1:       return 32'h7FFF_FFFF;
					2:       return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic row_vec_t rand_row();
		row_vec_t v;
		for (int j = 0; j < DIM; j++)
			v[j] = rand_elem();
		return v;
	endfunction

	task automatic add_cmd(input logic [1:0] op, input logic [1:0] row, input row_vec_t col);
		mm_cmd_t cmd;
		cmd.op = op;
		cmd.row = row;
		cmd.col = col;
		cmd.phase = 2'((n_items * 3) / RANDOM_ITEMS);
		pending_cmds.push_back(cmd);
	endtask

	// Driver: present the next pending item whenever the channel is free.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready)
				apply_cmd(drv_cmd);
			if (!in_valid || in_ready) begin
				if (pending_cmds.size() != 0 &&
				    $urandom_range(0, 99) >= sender_idle_pct(pending_cmds[0].phase)) begin
					drv_cmd = pending_cmds.pop_front();
					opcode     <= drv_cmd.op;
					row_sel    <= drv_cmd.row;
					in_c0      <= drv_cmd.col[0];
					in_c1      <= drv_cmd.col[1];
					in_c2      <= drv_cmd.col[2];
					in_c3      <= drv_cmd.col[3];
					test_phase <= drv_cmd.phase;
					in_valid   <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: check each accepted product row against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin : monitor
		prod_row_t want;
		row_vec_t  got;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {prod_c3, prod_c2, prod_c1, prod_c0};
				if (expected_rows.size() == 0) begin
					report($sformatf("unexpected row %0d", out_row));
				end else begin
					want = expected_rows.pop_front();
					if (out_row !== want.row)
						report($sformatf("out_row %0d, want %0d", out_row, want.row));
					for (int j = 0; j < DIM; j++)
						if (got[j] !== want.val[j])
							report($sformatf("row %0d prod_c%0d %h, want %h",
								want.row, j, got[j], want.val[j]));
					if (last_row !== want.last)
						report($sformatf("row %0d last_row %b, want %b",
							want.row, last_row, want.last));
				end
			end
			out_ready <= ($urandom_range(0, 99) >= receiver_idle_pct(test_phase));
		end
	end

	initial begin
		int        pick;
		logic [1:0] op;
		// An unused opcode before anything is loaded must change nothing.
		add_cmd(OP_UNUSED, 2'd3, {DIM{32'hFFFF_FFFF}});
		// Most negative times most negative: the sum overflows upward.
		for (int r = 0; r < DIM; r++)
			add_cmd(OP_LOAD_LEFT, 2'(r), {DIM{32'h8000_0000}});
		for (int r = 0; r < DIM; r++)
			add_cmd(OP_LOAD_RIGHT, 2'(r), {DIM{32'h8000_0000}});
		add_cmd(OP_MULTIPLY, 2'd0, '0);
		// Most negative times most positive: the sum overflows downward.
		for (int r = 0; r < DIM; r++)
			add_cmd(OP_LOAD_RIGHT, 2'(r), {DIM{32'h7FFF_FFFF}});
		add_cmd(OP_MULTIPLY, 2'd3, {DIM{32'hFFFF_FFFF}});
		// Tiny products show truncation toward minus infinity.
		add_cmd(OP_LOAD_LEFT, 2'd0, {32'h0, 32'h0, 32'h0, 32'h1});
		add_cmd(OP_LOAD_RIGHT, 2'd0, {32'h0001_0000, 32'h0, 32'h1, 32'hFFFF_FFFF});
		add_cmd(OP_MULTIPLY, 2'd1, {DIM{32'h5A5A_A5A5}});
		// Identity on the left reproduces the right matrix.
		for (int r = 0; r < DIM; r++) begin
			row_vec_t id;
			id = '0;
			id[r] = 32'h0001_0000;
			add_cmd(OP_LOAD_LEFT, 2'(r), id);
		end
		add_cmd(OP_UNUSED, 2'd0, {DIM{32'hFFFF_FFFF}});
		add_cmd(OP_MULTIPLY, 2'd2, '0);

		while (n_items < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				add_cmd(OP_UNUSED, 2'($urandom_range(0, 3)), rand_row());
				n_items++;
			end else if (pick < 16) begin
				// Rebuild one whole matrix, then multiply.
				op = $urandom_range(0, 1) ? OP_LOAD_RIGHT : OP_LOAD_LEFT;
				for (int r = 0; r < DIM; r++)
					add_cmd(op, 2'(r), rand_row());
				add_cmd(OP_MULTIPLY, 2'($urandom_range(0, 3)), rand_row());
				n_items += DIM + 1;
			end else if (pick < 50) begin
				add_cmd(OP_LOAD_LEFT, 2'($urandom_range(0, 3)), rand_row());
				n_items++;
			end else if (pick < 84) begin
				add_cmd(OP_LOAD_RIGHT, 2'($urandom_range(0, 3)), rand_row());
				n_items++;
			end else begin
				add_cmd(OP_MULTIPLY, 2'($urandom_range(0, 3)), rand_row());
				n_items++;
			end
		end

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_cmds.size() != 0 || in_valid || expected_rows.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rows.size() != 0)
			report($sformatf("%0d product rows never arrived", expected_rows.size()));

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

	initial begin
		#5ms;
		$display("Mismatches found");
		$finish;
	end

endmodule
